// File: src/fph_pkg.sv
// Package for the FNV-1a pixel hash core: constants, codes and shared types.
// Used by fph_ctrl, fph_datapath and fnv1a_pixel_hash_core; no dependencies.
package fph_pkg;

    localparam int HASH_W     = 64;
    localparam int DIM_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CNT_W      = 3;

    localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
    // prime = 2^40 + 0x1B3
    localparam logic [HASH_W-1:0] FNV_PRIME_LO     = 64'h0000_0000_0000_01B3;
    localparam int                FNV_PRIME_SHIFT  = 40;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic [CNT_W-1:0] HDR_LAST = 3'd7;
    localparam logic [CNT_W-1:0] PIX_LAST = 3'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_PIX,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_W0,
        SEL_W1,
        SEL_H0,
        SEL_H1,
        SEL_BLUE,
        SEL_GREEN,
        SEL_RED
    } byte_sel_t;

    typedef struct packed {
        logic      capture;
        logic      mix;
        logic      from_basis;
        byte_sel_t sel;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic eoi;
        logic out_free;
    } status_t;

endpackage

// File: src/fph_datapath.sv
// Datapath of the FNV-1a pixel hash core: pixel latch, hash register,
// one xor-multiply round per cycle while cmd.mix is set, and the output register. Uses fph_pkg.
module fph_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fph_pkg::cmd_t                 cmd,
    output fph_pkg::status_t              status,
    input  logic [fph_pkg::BYTE_W-1:0]    blue,
    input  logic [fph_pkg::BYTE_W-1:0]    green,
    input  logic [fph_pkg::BYTE_W-1:0]    red,
    input  logic                          end_of_image,
    input  logic [fph_pkg::DIM_W-1:0]     width,
    input  logic [fph_pkg::DIM_W-1:0]     height,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fph_pkg::HASH_W-1:0]    image_hash
);

    logic [fph_pkg::BYTE_W-1:0] blue_reg;
    logic [fph_pkg::BYTE_W-1:0] green_reg;
    logic [fph_pkg::BYTE_W-1:0] red_reg;
    logic                       eoi_reg;
    logic [fph_pkg::HASH_W-1:0] hash_reg;
    logic [fph_pkg::HASH_W-1:0] hash_next;
    logic [fph_pkg::HASH_W-1:0] image_hash_reg;
    logic [fph_pkg::HASH_W-1:0] image_hash_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [fph_pkg::BYTE_W-1:0] mix_byte;
    logic [fph_pkg::HASH_W-1:0] mix_src;
    logic [fph_pkg::HASH_W-1:0] mix_x;

    always_comb
    begin
        unique case (cmd.sel)
            fph_pkg::SEL_ZERO:  mix_byte = '0;
            fph_pkg::SEL_W0:    mix_byte = width[7:0];
            fph_pkg::SEL_W1:    mix_byte = width[15:8];
            fph_pkg::SEL_H0:    mix_byte = height[7:0];
            fph_pkg::SEL_H1:    mix_byte = height[15:8];
            fph_pkg::SEL_BLUE:  mix_byte = blue_reg;
            fph_pkg::SEL_GREEN: mix_byte = green_reg;
            fph_pkg::SEL_RED:   mix_byte = red_reg;
            default:            mix_byte = '0;
        endcase
    end

    always_comb
    begin
        mix_src   = cmd.from_basis ? fph_pkg::FNV_OFFSET_BASIS : hash_reg;
        mix_x     = mix_src ^ {{(fph_pkg::HASH_W-fph_pkg::BYTE_W){1'b0}}, mix_byte};
        hash_next = cmd.mix
                  ? (mix_x << fph_pkg::FNV_PRIME_SHIFT) + (mix_x * fph_pkg::FNV_PRIME_LO)
                  : hash_reg;
    end

    always_comb
    begin
        if (width == '0 || height == '0)
            image_hash_next = '0;
        else if (hash_reg == '0)
            image_hash_next = {{(fph_pkg::HASH_W-1){1'b0}}, 1'b1};
        else
            image_hash_next = hash_reg;

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            blue_reg  <= blue;
            green_reg <= green;
            red_reg   <= red;
            eoi_reg   <= end_of_image;
        end
        hash_reg <= hash_next;
        if (cmd.out_load)
            image_hash_reg <= image_hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.eoi      = eoi_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign image_hash      = image_hash_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a waiting result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_no_mix_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !cmd.mix && !cmd.capture)
        else $error("hash changed while result loaded");

endmodule

// File: src/fph_ctrl.sv
// Controller of the FNV-1a pixel hash core: sequences header bytes, pixel
// bytes and result hand-off, and drives the input stall. Uses fph_pkg.
module fph_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fph_pkg::status_t  status,
    output fph_pkg::cmd_t     cmd
);

    fph_pkg::state_t            state_reg;
    fph_pkg::state_t            state_next;
    logic [fph_pkg::CNT_W-1:0]  cnt_reg;
    logic [fph_pkg::CNT_W-1:0]  cnt_next;
    logic                       open_reg;
    logic                       open_next;
    logic                       take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fph_pkg::ST_IDLE;
            cnt_reg   <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        open_next      = open_reg;
        cmd.capture    = 1'b0;
        cmd.mix        = 1'b0;
        cmd.from_basis = 1'b0;
        cmd.sel        = fph_pkg::SEL_ZERO;
        cmd.out_load   = 1'b0;
        // next pixel may enter while the red byte of the previous one mixes
        in_stall = !((state_reg == fph_pkg::ST_IDLE) ||
                     (state_reg == fph_pkg::ST_PIX && cnt_reg == fph_pkg::PIX_LAST
                      && !status.eoi));
        take = in_valid && !in_stall;

        unique case (state_reg)
            fph_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    cmd.capture = 1'b1;
                    open_next   = 1'b1;
                    cnt_next    = '0;
                    state_next  = open_reg ? fph_pkg::ST_PIX : fph_pkg::ST_HDR;
                end
            end
            fph_pkg::ST_HDR:
            begin
                cmd.mix        = 1'b1;
                cmd.from_basis = (cnt_reg == '0);
                unique case (cnt_reg)
                    3'd0:    cmd.sel = fph_pkg::SEL_W0;
                    3'd1:    cmd.sel = fph_pkg::SEL_W1;
                    3'd4:    cmd.sel = fph_pkg::SEL_H0;
                    3'd5:    cmd.sel = fph_pkg::SEL_H1;
                    default: cmd.sel = fph_pkg::SEL_ZERO;
                endcase
                if (cnt_reg == fph_pkg::HDR_LAST)
                begin
                    cnt_next   = '0;
                    state_next = fph_pkg::ST_PIX;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            fph_pkg::ST_PIX:
            begin
                cmd.mix = 1'b1;
                unique case (cnt_reg)
                    3'd0:    cmd.sel = fph_pkg::SEL_BLUE;
                    3'd1:    cmd.sel = fph_pkg::SEL_GREEN;
                    default: cmd.sel = fph_pkg::SEL_RED;
                endcase
                if (cnt_reg == fph_pkg::PIX_LAST)
                begin
                    cnt_next = '0;
                    if (status.eoi)
                        state_next = fph_pkg::ST_FIN;
                    else if (take)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = fph_pkg::ST_PIX;
                    end
                    else
                        state_next = fph_pkg::ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            fph_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    open_next    = 1'b0;
                    state_next   = fph_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fph_pkg::ST_IDLE;
            end
        endcase
    end

    a_hdr_to_pix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fph_pkg::ST_HDR && cnt_reg == fph_pkg::HDR_LAST
        |=> state_reg == fph_pkg::ST_PIX && cnt_reg == '0)
        else $error("header did not hand over to pixel bytes");

    a_hdr_open: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fph_pkg::ST_HDR || state_reg == fph_pkg::ST_FIN |-> open_reg)
        else $error("header or close without an open image");

    a_pix_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fph_pkg::ST_PIX |-> cnt_reg <= fph_pkg::PIX_LAST)
        else $error("pixel byte counter out of range");

    a_eoi_closes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fph_pkg::ST_PIX && cnt_reg == fph_pkg::PIX_LAST && status.eoi
        |=> state_reg == fph_pkg::ST_FIN)
        else $error("end of image did not close the image");

endmodule

// File: src/fnv1a_pixel_hash_core.sv
// FNV-1a 64-bit pixel hash core, top level: size registers and config port.
// One multiply round by the FNV prime per mixing cycle in fph_datapath, sequenced by fph_ctrl.
// Each pixel mixes its blue, green and red bytes; the first pixel of an image follows 8 size bytes.
// The next pixel may enter while red mixes; after the closing pixel the result waits in ST_FIN for out_free.
// Reset (rst_n, async, active low): sizes 0, no image open, no result pending.
module fnv1a_pixel_hash_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fph_pkg::BYTE_W-1:0]        blue,
    input  logic [fph_pkg::BYTE_W-1:0]        green,
    input  logic [fph_pkg::BYTE_W-1:0]        red,
    input  logic                              end_of_image,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fph_pkg::HASH_W-1:0]        image_hash,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fph_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fph_pkg::DIM_W-1:0]         cfg_data
);

    logic [fph_pkg::DIM_W-1:0] width_reg;
    logic [fph_pkg::DIM_W-1:0] height_reg;
    fph_pkg::cmd_t             cmd;
    fph_pkg::status_t          status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fph_pkg::REG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            if (cfg_index == fph_pkg::REG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    fph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fph_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .end_of_image (end_of_image),
        .width        (width_reg),
        .height       (height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .image_hash   (image_hash)
    );

endmodule
